### sv/glh_pkg.sv
// Shared constants, types and helper functions of the grid histogram localizer.
package glh_pkg;

    // Grid geometry
    localparam int GRID_W = 20;
    localparam int GRID_H = 8;
    localparam int NCELL  = GRID_W * GRID_H;
    localparam int CELL_W = $clog2(NCELL);
    localparam int X_W    = $clog2(GRID_W);
    localparam int Y_W    = $clog2(GRID_H);

    // Datapath widths
    localparam int SUM_W = 32 + $clog2(NCELL);
    localparam int NUM_W = 63;
    localparam int QUO_W = 32;

    // Fixed-point constants
    localparam logic [16:0] ONE_Q16 = 17'h1_0000;
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [31:0] RECIP3  = 32'hAAAA_AAAB;

    // Commands
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_INIT   = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam logic [1:0] REG_SENSOR_NOISE    = 2'd0;
    localparam logic [1:0] REG_HEADING_NOISE   = 2'd1;
    localparam logic [1:0] REG_HEADING_BACK    = 2'd2;

    // Relative heading codes
    localparam logic [1:0] REL_SAME = 2'd0;
    localparam logic [1:0] REL_BACK = 2'd2;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } glh_div_stat_t;

    // Heading likelihood factor for a move in direction dir, Q1.16
    function automatic logic [16:0] head_fac(input logic [1:0] dir, input logic [1:0] head,
                                             input logic [15:0] hn, input logic [15:0] hbn);
        logic [1:0]  rel;
        logic [15:0] diff;
        rel  = dir ^ head;
        diff = hn - hbn;
        if (rel == REL_SAME)
            return ONE_Q16 - {1'b0, hn};
        else if (rel == REL_BACK)
            return {1'b0, hbn};
        else if (hn > hbn)
            return {2'b00, diff[15:1]};
        else
            return '0;
    endfunction

endpackage

### sv/glh_mul.sv
// Shared 32x32 multiplier with a registered product.
module glh_mul
    import glh_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    // Register the product for use in the next cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a) * 64'(b);
    end

    assign prod = prod_reg;

endmodule

### sv/glh_div.sv
// Restoring divider, one quotient bit per cycle.
module glh_div
    import glh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_W-1:0]     num,
    input  logic [SUM_W-1:0]     den,
    output logic [QUO_W-1:0]     quo,
    output glh_div_stat_t        stat
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [SUM_W-1:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]     den_reg, den_next;
    logic [QUO_W-1:0]     lo_reg, lo_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [SUM_W:0]       trial;
    logic                 fits;

    // Load the operands on start; while busy, shift in one dividend bit and subtract when the divisor fits
    always_comb
    begin
        trial     = {rem_reg, lo_reg[QUO_W-1]};
        fits      = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        lo_next   = lo_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            rem_next  = SUM_W'(num[NUM_W-1:QUO_W]);
            lo_next   = num[QUO_W-1:0];
            den_next  = den;
            cnt_next  = 6'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? SUM_W'(trial - {1'b0, den_reg}) : trial[SUM_W-1:0];
            lo_next  = {lo_reg[QUO_W-2:0], 1'b0};
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != 6'd0))
        else $error("divider busy with an empty bit count");
`endif

endmodule

### sv/grid_histogram_localizer_unit.sv
// Top level: command sequencer, map and belief memories, shared multiplier and divider.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+------------------------------------------
//  in      | in        | in_valid/in_stall  | cmd, cell_req, wall_bit, sensor_bits, heading
//  out     | out       | out_valid/out_stall| value, best_cell, best_count, status
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//
//  Init counts the free cells, divides one by their number and writes that belief
//  to every cell. Update builds the neighbour masks, spreads the shares of each
//  free cell to its free neighbours, sums the next beliefs and normalizes them.
//  Both then build the summary.
//  The single multiplier and the bit-serial divider are shared by these phases.
//  Reset clears beliefs through per-cell valid bits; no clearing pass is needed.
//  in_stall is high from acceptance until the result is placed in the output
//  register; a new word is taken while that result still waits under out_stall.
module grid_histogram_localizer_unit
    import glh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  cell_req,
    input  logic        wall_bit,
    input  logic [3:0]  sensor_bits,
    input  logic [1:0]  heading,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] value,
    output logic [7:0]  best_cell,
    output logic [7:0]  best_count,
    output logic        status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_LOAD     = 12'b0000_0000_0010,
        S_READ     = 12'b0000_0000_0100,
        S_INIT_CNT = 12'b0000_0000_1000,
        S_INIT_DIV = 12'b0000_0001_0000,
        S_INIT_WR  = 12'b0000_0010_0000,
        S_MASK     = 12'b0000_0100_0000,
        S_SPREAD   = 12'b0000_1000_0000,
        S_SUM      = 12'b0001_0000_0000,
        S_NORM     = 12'b0010_0000_0000,
        S_SUMM     = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } state_t;

    state_t              state_reg, state_next, adv_state;

    // Configuration
    logic [15:0]         sn_reg, hn_reg, hbn_reg;

    // Latched command word
    cmd_t                cmd_reg, cmd_next;
    logic [7:0]          cell_in_reg, cell_in_next;
    logic                wall_in_reg, wall_in_next;
    logic [3:0]          sens_reg, sens_next;
    logic [1:0]          head_reg, head_next;

    // Sweep position
    logic [CELL_W-1:0]   cell_reg, cell_next;
    logic [X_W-1:0]      x_reg, x_next;
    logic [Y_W-1:0]      y_reg, y_next;
    logic [3:0]          step_reg, step_next;
    logic [1:0]          dir_reg, dir_next;
    logic [1:0]          k_reg, k_next;
    logic                adv;

    // Update datapath
    logic                own_reg, own_next;
    logic [3:0]          m_reg, m_next;
    logic [3:0]          c_mask_reg, c_mask_next;
    logic [31:0]         c_bel_reg, c_bel_next;
    logic [CELL_W-1:0]   n_reg, n_next;
    logic [3:0]          n_mask_reg, n_mask_next;
    logic [16:0]         lik_reg, lik_next;
    logic [31:0]         share_reg, share_next;
    logic [SUM_W-1:0]    sum_reg, sum_next, sum_total;
    logic [31:0]         q_reg, q_next;
    logic [CELL_W:0]     fc_reg, fc_next;

    // Result
    logic [31:0]         maxv_reg, maxv_next;
    logic [7:0]          best_reg, best_next;
    logic [7:0]          cnt_reg, cnt_next;
    logic                stat_reg, stat_next;
    logic                out_load;
    logic                out_valid_reg;
    logic [31:0]         value_reg;
    logic [7:0]          best_cell_reg, best_count_reg;
    logic                status_reg;

    // Neighbours of the current cell
    logic [3:0]          nb_ok;
    logic [CELL_W-1:0]   nb_addr [4];
    logic [CELL_W-1:0]   nb_rd [4];
    logic [2:0]          nfree;
    logic [16:0]         sens_fac;
    logic [32:0]         acc;
    logic [31:0]         bel_val, nxt_val;
    logic                cell_ok;

    // Memories
    logic                wall_mem [NCELL];
    logic                wall_we, wall_rd_reg;
    logic [CELL_W-1:0]   wall_waddr, wall_raddr;
    logic [4:0]          info_mem [NCELL];
    logic                info_we;
    logic [4:0]          info_wdata, info_rd_reg;
    logic [CELL_W-1:0]   info_raddr;
    logic [31:0]         bel_mem [NCELL];
    logic [NCELL-1:0]    bel_vld_reg;
    logic                bel_we, bel_clr, bel_rv_reg;
    logic [CELL_W-1:0]   bel_waddr, bel_raddr;
    logic [31:0]         bel_wdata, bel_rd_reg;
    logic [31:0]         nxt_mem [NCELL];
    logic [NCELL-1:0]    nxt_vld_reg;
    logic                nxt_we, nxt_clr, nxt_rv_reg;
    logic [CELL_W-1:0]   nxt_raddr;
    logic [31:0]         nxt_wdata, nxt_rd_reg;

    // Shared units
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         mul_prod;
    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    logic [SUM_W-1:0]    div_den;
    logic [QUO_W-1:0]    div_quo;
    glh_div_stat_t       div_st;

    glh_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    glh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .stat  (div_st)
    );

    // Wall map
    always_ff @(posedge clk)
    begin
        if (wall_we)
            wall_mem[wall_waddr] <= wall_in_reg;
        wall_rd_reg <= wall_mem[wall_raddr];
    end

    // Own wall flag and free-neighbour mask per cell
    always_ff @(posedge clk)
    begin
        if (info_we)
            info_mem[cell_reg] <= info_wdata;
        info_rd_reg <= info_mem[info_raddr];
    end

    // Beliefs
    always_ff @(posedge clk)
    begin
        if (bel_we)
            bel_mem[bel_waddr] <= bel_wdata;
        bel_rd_reg <= bel_mem[bel_raddr];
        bel_rv_reg <= bel_vld_reg[bel_raddr];
    end

    // Next beliefs
    always_ff @(posedge clk)
    begin
        if (nxt_we)
            nxt_mem[n_reg] <= nxt_wdata;
        nxt_rd_reg <= nxt_mem[nxt_raddr];
        nxt_rv_reg <= nxt_vld_reg[nxt_raddr];
    end

    // Valid bits: an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bel_vld_reg <= '0;
            nxt_vld_reg <= '0;
        end
        else
        begin
            if (bel_clr)
                bel_vld_reg <= '0;
            else if (bel_we)
                bel_vld_reg[bel_waddr] <= 1'b1;
            if (nxt_clr)
                nxt_vld_reg <= '0;
            else if (nxt_we)
                nxt_vld_reg[n_reg] <= 1'b1;
        end
    end

    // Neighbour addresses and edge checks
    always_comb
    begin
        nb_ok[0]   = x_reg != X_W'(GRID_W - 1);
        nb_ok[1]   = y_reg != '0;
        nb_ok[2]   = x_reg != '0;
        nb_ok[3]   = y_reg != Y_W'(GRID_H - 1);
        nb_addr[0] = cell_reg + CELL_W'(1);
        nb_addr[1] = cell_reg - CELL_W'(GRID_W);
        nb_addr[2] = cell_reg - CELL_W'(1);
        nb_addr[3] = cell_reg + CELL_W'(GRID_W);
        for (int d = 0; d < 4; d++)
            nb_rd[d] = nb_ok[d] ? nb_addr[d] : cell_reg;
    end

    assign bel_val  = bel_rv_reg ? bel_rd_reg : '0;
    assign nxt_val  = nxt_rv_reg ? nxt_rd_reg : '0;
    assign nfree    = 3'($countones(c_mask_reg));
    assign sens_fac = (n_mask_reg[k_reg] != sens_reg[k_reg]) ? {1'b0, sn_reg}
                                                              : ONE_Q16 - {1'b0, sn_reg};
    assign cell_ok  = int'(cell_in_reg) < NCELL;
    assign sum_total = sum_reg + SUM_W'(nxt_val);
    assign acc      = 33'(nxt_val) + 33'(share_reg);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        adv_state    = state_reg;
        adv          = 1'b0;
        cmd_next     = cmd_reg;
        cell_in_next = cell_in_reg;
        wall_in_next = wall_in_reg;
        sens_next    = sens_reg;
        head_next    = head_reg;
        cell_next    = cell_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        step_next    = step_reg;
        dir_next     = dir_reg;
        k_next       = k_reg;
        own_next     = own_reg;
        m_next       = m_reg;
        c_mask_next  = c_mask_reg;
        c_bel_next   = c_bel_reg;
        n_next       = n_reg;
        n_mask_next  = n_mask_reg;
        lik_next     = lik_reg;
        share_next   = share_reg;
        sum_next     = sum_reg;
        q_next       = q_reg;
        fc_next      = fc_reg;
        maxv_next    = maxv_reg;
        best_next    = best_reg;
        cnt_next     = cnt_reg;
        stat_next    = stat_reg;
        out_load     = 1'b0;
        wall_we      = 1'b0;
        wall_waddr   = cell_in_reg[CELL_W-1:0];
        wall_raddr   = cell_reg;
        info_we      = 1'b0;
        info_wdata   = {own_reg, nb_ok[3] & ~wall_rd_reg, m_reg[2:0]};
        info_raddr   = cell_reg;
        bel_we       = 1'b0;
        bel_clr      = 1'b0;
        bel_waddr    = cell_reg;
        bel_wdata    = q_reg;
        bel_raddr    = cell_reg;
        nxt_we       = 1'b0;
        nxt_clr      = 1'b0;
        nxt_raddr    = n_reg;
        nxt_wdata    = (acc > 33'(ONE_Q31)) ? ONE_Q31 : acc[31:0];
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_num      = {nxt_val, 31'b0};
        div_den      = sum_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // Take a command word
                if (in_valid)
                begin
                    cmd_next     = cmd_t'(cmd);
                    cell_in_next = cell_req;
                    wall_in_next = wall_bit;
                    sens_next    = sensor_bits;
                    head_next    = heading;
                    cell_next    = '0;
                    x_next       = '0;
                    y_next       = '0;
                    step_next    = '0;
                    dir_next     = '0;
                    unique case (cmd_t'(cmd))
                        CMD_LOAD:   state_next = S_LOAD;
                        CMD_READ:   state_next = S_READ;
                        CMD_INIT:
                        begin
                            fc_next    = '0;
                            state_next = S_INIT_CNT;
                        end
                        CMD_UPDATE:
                        begin
                            nxt_clr    = 1'b1;
                            stat_next  = 1'b0;
                            state_next = S_MASK;
                        end
                        default:    state_next = S_IDLE;
                    endcase
                end
            end

            S_LOAD:
            begin
                // Write one map flag, drop it when out of range
                wall_we    = cell_ok;
                maxv_next  = '0;
                best_next  = '0;
                cnt_next   = '0;
                stat_next  = 1'b0;
                state_next = S_DONE;
            end

            S_READ:
            begin
                bel_raddr = cell_in_reg[CELL_W-1:0];
                if (step_reg == 4'd0)
                    step_next = 4'd1;
                else
                begin
                    maxv_next  = cell_ok ? bel_val : '0;
                    best_next  = cell_in_reg;
                    cnt_next   = '0;
                    stat_next  = 1'b0;
                    state_next = S_DONE;
                end
            end

            S_INIT_CNT:
            begin
                // Count free cells
                if (step_reg == 4'd0)
                    step_next = 4'd1;
                else
                begin
                    if (!wall_rd_reg)
                        fc_next = fc_reg + 1'b1;
                    adv       = 1'b1;
                    adv_state = S_INIT_DIV;
                end
            end

            S_INIT_DIV:
            begin
                div_num = NUM_W'(ONE_Q31);
                div_den = SUM_W'(fc_reg);
                if (step_reg == 4'd0)
                begin
                    if (fc_reg == '0)
                    begin
                        q_next     = '0;
                        stat_next  = 1'b1;
                        state_next = S_INIT_WR;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        step_next = 4'd1;
                    end
                end
                else if (div_st.done)
                begin
                    q_next     = div_quo;
                    stat_next  = 1'b0;
                    step_next  = '0;
                    state_next = S_INIT_WR;
                end
            end

            S_INIT_WR:
            begin
                // Spread the uniform belief over every cell
                bel_we    = 1'b1;
                adv       = 1'b1;
                adv_state = S_SUMM;
            end

            S_MASK:
            begin
                // Gather own wall flag and free-neighbour mask
                unique case (step_reg)
                    4'd0:
                    begin
                        step_next = 4'd1;
                    end
                    4'd1:
                    begin
                        own_next   = wall_rd_reg;
                        wall_raddr = nb_rd[0];
                        step_next  = 4'd2;
                    end
                    4'd2:
                    begin
                        m_next[0]  = nb_ok[0] & ~wall_rd_reg;
                        wall_raddr = nb_rd[1];
                        step_next  = 4'd3;
                    end
                    4'd3:
                    begin
                        m_next[1]  = nb_ok[1] & ~wall_rd_reg;
                        wall_raddr = nb_rd[2];
                        step_next  = 4'd4;
                    end
                    4'd4:
                    begin
                        m_next[2]  = nb_ok[2] & ~wall_rd_reg;
                        wall_raddr = nb_rd[3];
                        step_next  = 4'd5;
                    end
                    default:
                    begin
                        info_we   = 1'b1;
                        adv       = 1'b1;
                        adv_state = S_SPREAD;
                    end
                endcase
            end

            S_SPREAD:
            begin
                // Push weighted shares of each free cell to its free neighbours
                unique case (step_reg)
                    4'd0:
                    begin
                        step_next = 4'd1;
                    end
                    4'd1:
                    begin
                        c_mask_next = info_rd_reg[3:0];
                        c_bel_next  = bel_val;
                        dir_next    = '0;
                        if (info_rd_reg[4] || info_rd_reg[3:0] == 4'd0)
                        begin
                            adv       = 1'b1;
                            adv_state = S_SUM;
                        end
                        else
                            step_next = 4'd2;
                    end
                    4'd2:
                    begin
                        info_raddr = nb_rd[dir_reg];
                        if (c_mask_reg[dir_reg])
                        begin
                            n_next    = nb_addr[dir_reg];
                            step_next = 4'd3;
                        end
                        else if (dir_reg == 2'd3)
                        begin
                            adv       = 1'b1;
                            adv_state = S_SUM;
                        end
                        else
                            dir_next = dir_reg + 2'd1;
                    end
                    4'd3:
                    begin
                        n_mask_next = info_rd_reg[3:0];
                        k_next      = '0;
                        lik_next    = ONE_Q16;
                        step_next   = 4'd4;
                    end
                    4'd4:
                    begin
                        mul_a     = 32'(lik_reg);
                        mul_b     = 32'(sens_fac);
                        step_next = 4'd5;
                    end
                    4'd5:
                    begin
                        lik_next = mul_prod[32:16];
                        if (k_reg == 2'd3)
                            step_next = 4'd6;
                        else
                        begin
                            k_next    = k_reg + 2'd1;
                            step_next = 4'd4;
                        end
                    end
                    4'd6:
                    begin
                        mul_a     = 32'(lik_reg);
                        mul_b     = 32'(head_fac(dir_reg, head_reg, hn_reg, hbn_reg));
                        step_next = 4'd7;
                    end
                    4'd7:
                    begin
                        lik_next  = mul_prod[32:16];
                        step_next = 4'd8;
                    end
                    4'd8:
                    begin
                        mul_a     = c_bel_reg;
                        mul_b     = 32'(lik_reg);
                        step_next = 4'd9;
                    end
                    4'd9:
                    begin
                        share_next = mul_prod[47:16];
                        mul_a      = mul_prod[47:16];
                        mul_b      = RECIP3;
                        step_next  = 4'd10;
                    end
                    4'd10:
                    begin
                        // Divide by the free-neighbour count
                        unique case (nfree)
                            3'd2:    share_next = share_reg >> 1;
                            3'd3:    share_next = {1'b0, mul_prod[63:33]};
                            3'd4:    share_next = share_reg >> 2;
                            default: share_next = share_reg;
                        endcase
                        step_next = 4'd11;
                    end
                    default:
                    begin
                        // Accumulate with saturation at one
                        nxt_we = 1'b1;
                        if (dir_reg == 2'd3)
                        begin
                            adv       = 1'b1;
                            adv_state = S_SUM;
                        end
                        else
                        begin
                            dir_next  = dir_reg + 2'd1;
                            step_next = 4'd2;
                        end
                    end
                endcase
            end

            S_SUM:
            begin
                nxt_raddr = cell_reg;
                if (step_reg == 4'd0)
                    step_next = 4'd1;
                else
                begin
                    sum_next = sum_total;
                    adv      = 1'b1;
                    if (sum_total == '0)
                    begin
                        adv_state = S_SUMM;
                        if (cell_reg == CELL_W'(NCELL - 1))
                        begin
                            bel_clr   = 1'b1;
                            stat_next = 1'b1;
                        end
                    end
                    else
                        adv_state = S_NORM;
                end
            end

            S_NORM:
            begin
                // Normalize one cell through the divider
                nxt_raddr = cell_reg;
                bel_wdata = div_quo;
                unique case (step_reg)
                    4'd0:
                    begin
                        step_next = 4'd1;
                    end
                    4'd1:
                    begin
                        div_start = 1'b1;
                        step_next = 4'd2;
                    end
                    default:
                    begin
                        if (div_st.done)
                        begin
                            bel_we    = 1'b1;
                            adv       = 1'b1;
                            adv_state = S_SUMM;
                        end
                    end
                endcase
            end

            S_SUMM:
            begin
                // Track maximum, its first cell and its count
                if (step_reg == 4'd0)
                    step_next = 4'd1;
                else
                begin
                    if (bel_val > maxv_reg)
                    begin
                        maxv_next = bel_val;
                        best_next = 8'(cell_reg);
                        cnt_next  = 8'd1;
                    end
                    else if (bel_val == maxv_reg && cnt_reg != 8'hFF)
                        cnt_next = cnt_reg + 8'd1;
                    adv       = 1'b1;
                    adv_state = S_DONE;
                end
            end

            S_DONE:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Advance the sweep, or enter the next phase after the last cell
        if (adv)
        begin
            step_next = '0;
            dir_next  = '0;
            if (cell_reg == CELL_W'(NCELL - 1))
            begin
                state_next = adv_state;
                cell_next  = '0;
                x_next     = '0;
                y_next     = '0;
                if (adv_state == S_SUMM)
                begin
                    maxv_next = '0;
                    best_next = '0;
                    cnt_next  = '0;
                end
                if (adv_state == S_SUM)
                    sum_next = '0;
            end
            else
            begin
                cell_next = cell_reg + CELL_W'(1);
                if (x_reg == X_W'(GRID_W - 1))
                begin
                    x_next = '0;
                    y_next = y_reg + Y_W'(1);
                end
                else
                    x_next = x_reg + X_W'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            sn_reg        <= 16'd8192;
            hn_reg        <= 16'd4096;
            hbn_reg       <= 16'd256;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_we && cfg_index == REG_SENSOR_NOISE)
                sn_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_HEADING_NOISE)
                hn_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_HEADING_BACK)
                hbn_reg <= cfg_data;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        cell_in_reg <= cell_in_next;
        wall_in_reg <= wall_in_next;
        sens_reg    <= sens_next;
        head_reg    <= head_next;
        cell_reg    <= cell_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        step_reg    <= step_next;
        dir_reg     <= dir_next;
        k_reg       <= k_next;
        own_reg     <= own_next;
        m_reg       <= m_next;
        c_mask_reg  <= c_mask_next;
        c_bel_reg   <= c_bel_next;
        n_reg       <= n_next;
        n_mask_reg  <= n_mask_next;
        lik_reg     <= lik_next;
        share_reg   <= share_next;
        sum_reg     <= sum_next;
        q_reg       <= q_next;
        fc_reg      <= fc_next;
        maxv_reg    <= maxv_next;
        best_reg    <= best_next;
        cnt_reg     <= cnt_next;
        stat_reg    <= stat_next;
        if (out_load)
        begin
            value_reg      <= maxv_reg;
            best_cell_reg  <= best_reg;
            best_count_reg <= cnt_reg;
            status_reg     <= stat_reg;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign best_cell  = best_cell_reg;
    assign best_count = best_count_reg;
    assign status     = status_reg;

`ifndef SYNTHESIS
    a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_INIT_DIV || state_reg == S_NORM))
        else $error("divider result outside a dividing phase");
    a_norm_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NORM) |-> (sum_reg != '0))
        else $error("normalization with a zero belief sum");
    a_next_sat: assert property (@(posedge clk) disable iff (!rst_n)
        nxt_we |-> (nxt_wdata <= ONE_Q31))
        else $error("next belief above one");
    a_spread_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPREAD && step_reg >= 4'd3) |-> c_mask_reg[dir_reg])
        else $error("share sent toward a blocked neighbour");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the grid histogram localizer: scoreboard class and stimulus.
`timescale 1ns / 1ps

module tb_top;
    import glh_pkg::*;

    // Predicted output word of the block
    typedef struct {
        logic [31:0] value;
        logic [7:0]  best_cell;
        logic [7:0]  best_count;
        logic        status;
    } loc_word_t;

    // Belief tracker: own copy of map, beliefs and noise settings
    class localizer_scoreboard;
        bit               wall[NCELL];
        longint unsigned  belief[NCELL];
        longint unsigned  sens_noise;
        longint unsigned  head_noise;
        longint unsigned  back_noise;
        loc_word_t        expected_q[$];
        int               errors;

        function new();
            foreach (wall[i]) wall[i] = 1'b0;
            foreach (belief[i]) belief[i] = 0;
            sens_noise = 8192;
            head_noise = 4096;
            back_noise = 256;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            if (idx == REG_SENSOR_NOISE) sens_noise = data;
            else if (idx == REG_HEADING_NOISE) head_noise = data;
            else if (idx == REG_HEADING_BACK) back_noise = data;
        endfunction

        // Neighbor cell in direction dir, or -1 off the grid
        function int step_cell(int c, int dir);
            int x;
            int y;
            x = c % GRID_W;
            y = c / GRID_W;
            case (dir)
                0: if (x + 1 >= GRID_W) return -1; else x++;
                1: if (y == 0) return -1; else y--;
                2: if (x == 0) return -1; else x--;
                default: if (y + 1 >= GRID_H) return -1; else y++;
            endcase
            return x + y * GRID_W;
        endfunction

        function bit open_dir(int c, int dir);
            int n;
            n = step_cell(c, dir);
            return (n >= 0) && !wall[n];
        endfunction

        // Observation likelihood for arriving at np by a move in direction dir
        function longint unsigned move_lik(int np, int dir, bit [3:0] sens, bit [1:0] head);
            longint unsigned l;
            longint unsigned fac;
            bit [1:0] rel;
            l = 65536;
            for (int k = 0; k < 4; k++) begin
                fac = (open_dir(np, k) != sens[k]) ? sens_noise : 65536 - sens_noise;
                l = (l * fac) >> 16;
            end
            rel = dir[1:0] ^ head;
            if (rel == REL_SAME) fac = 65536 - head_noise;
            else if (rel == REL_BACK) fac = back_noise;
            else fac = (head_noise > back_noise) ? (head_noise - back_noise) >> 1 : 0;
            return (l * fac) >> 16;
        endfunction

        function void summarize(ref loc_word_t w, input bit st);
            longint unsigned maxv;
            int best;
            int cnt;
            maxv = 0;
            best = 0;
            cnt  = 0;
            for (int i = 0; i < NCELL; i++) begin
                if (belief[i] > maxv) begin
                    maxv = belief[i];
                    best = i;
                    cnt  = 1;
                end else if (belief[i] == maxv) cnt++;
            end
            w.value      = maxv[31:0];
            w.best_cell  = best[7:0];
            w.best_count = (cnt > 255) ? 8'd255 : cnt[7:0];
            w.status     = st;
        endfunction

        // Forward update; returns 1 on a zero belief sum
        function bit forward_update(bit [3:0] sens, bit [1:0] head);
            longint unsigned nxt[NCELL];
            longint unsigned lik[4];
            longint unsigned sum;
            longint unsigned share;
            int nfree;
            int n;
            foreach (nxt[i]) nxt[i] = 0;
            for (int c = 0; c < NCELL; c++) begin
                if (wall[c]) continue;
                nfree = 0;
                for (int d = 0; d < 4; d++) begin
                    lik[d] = 0;
                    if (open_dir(c, d)) begin
                        lik[d] = move_lik(step_cell(c, d), d, sens, head);
                        nfree++;
                    end
                end
                if (nfree == 0) continue;
                for (int d = 0; d < 4; d++) begin
                    if (!open_dir(c, d)) continue;
                    n = step_cell(c, d);
                    share = ((belief[c] * lik[d]) >> 16) / nfree;
                    nxt[n] += share;
                    if (nxt[n] > 64'h8000_0000) nxt[n] = 64'h8000_0000;
                end
            end
            sum = 0;
            foreach (nxt[i]) sum += nxt[i];
            if (sum == 0) begin
                foreach (belief[i]) belief[i] = 0;
                return 1'b1;
            end
            foreach (belief[i]) belief[i] = (nxt[i] << 31) / sum;
            return 1'b0;
        endfunction

        // Note an accepted input word and queue its predicted result
        function void note_input(cmd_t op, bit [7:0] c, bit wb, bit [3:0] sens, bit [1:0] head);
            loc_word_t w;
            int fc;
            longint unsigned q;
            w = '{default: '0};
            case (op)
                CMD_LOAD: if (c < NCELL) wall[c] = wb;
                CMD_INIT: begin
                    fc = 0;
                    foreach (wall[i]) if (!wall[i]) fc++;
                    q = (fc == 0) ? 0 : 64'h8000_0000 / fc;
                    foreach (belief[i]) belief[i] = q;
                    summarize(w, fc == 0);
                end
                CMD_UPDATE: summarize(w, forward_update(sens, head));
                default: begin
                    w.value     = (c < NCELL) ? belief[c][31:0] : 32'd0;
                    w.best_cell = c;
                end
            endcase
            expected_q.push_back(w);
        endfunction

        // Compare an accepted output word with the oldest prediction
        function void check_word(loc_word_t got);
            loc_word_t e;
            if (expected_q.size() == 0) begin
                $error("unexpected output word: value %0d", got.value);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.value !== e.value) begin
                $error("value: expected %0d, got %0d", e.value, got.value);
                errors++;
            end
            if (got.best_cell !== e.best_cell) begin
                $error("best_cell: expected %0d, got %0d", e.best_cell, got.best_cell);
                errors++;
            end
            if (got.best_count !== e.best_count) begin
                $error("best_count: expected %0d, got %0d", e.best_count, got.best_count);
                errors++;
            end
            if (got.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = CMD_READ;
    logic [7:0]  cell_req = '0;
    logic        wall_bit = 1'b0;
    logic [3:0]  sensor_bits = '0;
    logic [1:0]  heading = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] value;
    logic [7:0]  best_cell;
    logic [7:0]  best_count;
    logic        status;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    bit quiet = 1'b0;
    localizer_scoreboard belief_sb = new();

    grid_histogram_localizer_unit dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Random output stall, off during the quiet stretch
    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < 27);
    end

    // Check every accepted output word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            belief_sb.check_word('{value, best_cell, best_count, status});
    end

    // Present one word, hold it until accepted
    task automatic send_word(cmd_t op, bit [7:0] c, bit wb = 1'b0,
                             bit [3:0] sens = 4'd0, bit [1:0] head = 2'd0);
        while (!quiet && $urandom_range(99) < 27) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= op;
        cell_req    <= c;
        wall_bit    <= wb;
        sensor_bits <= sens;
        heading     <= head;
        do @(posedge clk); while (in_stall);
        belief_sb.note_input(op, c, wb, sens, head);
    endtask

    // Drop valid and wait for every predicted word to drain
    task automatic drain();
        in_valid <= 1'b0;
        while (belief_sb.expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        belief_sb.set_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic random_word();
        int r;
        bit [7:0] c;
        r = $urandom_range(99);
        c = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(NCELL - 1));
        if (r < 30) send_word(CMD_LOAD, c, $urandom_range(99) < 25);
        else if (r < 40) send_word(CMD_INIT, c);
        else if (r < 60) send_word(CMD_UPDATE, c, 1'b0, 4'($urandom_range(15)),
                                   2'($urandom_range(3)));
        else send_word(CMD_READ, c);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reads before init, out-of-range cells
        send_word(CMD_READ, 8'd0);
        send_word(CMD_READ, 8'd255);
        send_word(CMD_LOAD, 8'd200, 1'b1);
        send_word(CMD_READ, 8'd159);
        // All walls: init with no free cells, then a zero-sum update
        for (int i = 0; i < NCELL; i++) send_word(CMD_LOAD, 8'(i), 1'b1);
        send_word(CMD_INIT, 8'd0);
        send_word(CMD_UPDATE, 8'd0, 1'b0, 4'hF, 2'd3);
        // Lone free cell has no free neighbor
        send_word(CMD_LOAD, 8'd0, 1'b0);
        send_word(CMD_INIT, 8'd0);
        send_word(CMD_UPDATE, 8'd0, 1'b0, 4'h0, 2'd0);
        // Three free cells, every heading
        send_word(CMD_LOAD, 8'd1, 1'b0);
        send_word(CMD_LOAD, 8'd21, 1'b0);
        for (int h = 0; h < 4; h++) begin
            send_word(CMD_INIT, 8'd0);
            send_word(CMD_UPDATE, 8'd0, 1'b0, 4'(h * 5), 2'(h));
            send_word(CMD_READ, 8'd1);
        end

        // Open a random set of cells, then mixed traffic at the reset settings
        for (int i = 0; i < NCELL; i++)
            if ($urandom_range(99) < 40) send_word(CMD_LOAD, 8'(i), 1'b0);
        send_word(CMD_INIT, 8'd0);
        repeat (10) random_word();

        // Walk the noise settings, extremes first
        for (int p = 0; p < 4; p++) begin
            drain();
            case (p)
                0: begin
                    write_reg(REG_SENSOR_NOISE, 16'd0);
                    write_reg(REG_HEADING_NOISE, 16'd0);
                    write_reg(REG_HEADING_BACK, 16'd0);
                end
                1: begin
                    write_reg(REG_SENSOR_NOISE, 16'd32768);
                    write_reg(REG_HEADING_NOISE, 16'd32768);
                    write_reg(REG_HEADING_BACK, 16'd32768);
                end
                2: begin
                    write_reg(REG_SENSOR_NOISE, 16'($urandom_range(32768)));
                    write_reg(REG_HEADING_NOISE, 16'($urandom_range(2000)));
                    write_reg(REG_HEADING_BACK, 16'($urandom_range(32768, 4000)));
                end
                default: begin
                    write_reg(REG_SENSOR_NOISE, 16'($urandom_range(32768)));
                    write_reg(REG_HEADING_NOISE, 16'($urandom_range(32768)));
                    write_reg(REG_HEADING_BACK, 16'($urandom_range(4000)));
                end
            endcase
            quiet = (p == 2);
            send_word(CMD_INIT, 8'd0);
            repeat (4) random_word();
            // In the last pass, hold off the sender until the block has drained
            if (p == 3) drain();
            repeat (4) random_word();
        end
        quiet = 1'b0;

        drain();
        repeat (50) @(posedge clk);
        if (belief_sb.errors == 0)
            $display("** grid_histogram_localizer_unit: PASSED **");
        else
            $display("** grid_histogram_localizer_unit: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #50_000_000;
        $display("** grid_histogram_localizer_unit: FAILED **");
        $finish;
    end

endmodule

### sim.f
sv/glh_pkg.sv
sv/glh_mul.sv
sv/glh_div.sv
sv/grid_histogram_localizer_unit.sv
tb/tb_top.sv
